### design/imm_pkg.sv
// shared types, constants and helpers for the integer matrix multiplier
`timescale 1ns / 1ps
`default_nettype none
package imm_pkg;

    localparam int MAX_DIM = 8;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DATA_W  = 32;
    localparam int CFG_W   = 4;
    localparam int IDX_W   = 3;

    // drain count at which busy drops, so the final result shows with busy low
    localparam logic [1:0] DRAIN_LAST = 2'd1;

    typedef enum logic [1:0] {
        KIND_LOAD_A = 2'd0,
        KIND_LOAD_B = 2'd1,
        KIND_START  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CFG_ROWS  = 2'd0,
        CFG_INNER = 2'd1,
        CFG_COLS  = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last_k;
        logic             last_el;
        logic [CNT_W-1:0] row;
        logic [CNT_W-1:0] col;
    } issue_tag_t;

    // highest index for a dimension register: zero acts as one, clamp to MAX_DIM
    function automatic logic [CNT_W-1:0] dim_last(input logic [CFG_W-1:0] r);
        logic [CNT_W-1:0] res;
        if (r == '0)
        begin
            res = '0;
        end
        else if (32'(r) > MAX_DIM)
        begin
            res = CNT_W'(MAX_DIM - 1);
        end
        else
        begin
            res = CNT_W'(r - CFG_W'(1));
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### design/integer_matrix_multiply_top.sv
// top level of the integer matrix multiplier
//
// usage:
//   a beat is taken at a rising edge with start high and busy low.
//   kind 0 or 1 writes value into A or B at (row_index, col_index);
//   kind 3 is dropped. kind 2 runs the product A*B over the current
//   rows, inner and cols registers (zero acts as one, larger than MAX_DIM
//   is clamped) and raises busy until the last result is in the output
//   register.
//   results come out in row-major order, each for one cycle with
//   result_strobe high; last marks the final element. there is no stall.
//   one multiply-accumulate unit runs one inner step per cycle, and busy
//   drops in the cycle of the last result. the first result passes
//   through the store read register, the product register and the
//   result register.
//   configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
//   and are meant only while busy is low.
//   reset sets rows, inner and cols to 8 and makes both stores read zero
//   through per-entry valid bits; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module integer_matrix_multiply_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  kind,
    input  wire logic [imm_pkg::IDX_W-1:0]   row_index,
    input  wire logic [imm_pkg::IDX_W-1:0]   col_index,
    input  wire logic signed [31:0]          value,
    input  wire logic                        cfg_we,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [imm_pkg::CFG_W-1:0]   cfg_data,
    output logic                             result_strobe,
    output logic [imm_pkg::IDX_W-1:0]        out_row,
    output logic [imm_pkg::IDX_W-1:0]        out_col,
    output logic signed [31:0]               product_value,
    output logic                             last
);

    logic [imm_pkg::CFG_W-1:0]    rows_reg;
    logic [imm_pkg::CFG_W-1:0]    inner_reg;
    logic [imm_pkg::CFG_W-1:0]    cols_reg;
    logic                         accept;
    logic                         in_range;
    logic                         we_a;
    logic                         we_b;
    logic                         go;
    logic [imm_pkg::ADDR_W-1:0]   waddr;
    logic [imm_pkg::ADDR_W-1:0]   a_raddr;
    logic [imm_pkg::ADDR_W-1:0]   b_raddr;
    logic [imm_pkg::DATA_W-1:0]   a_data;
    logic [imm_pkg::DATA_W-1:0]   b_data;
    logic [imm_pkg::DATA_W-1:0]   sum;
    imm_pkg::issue_tag_t          tag;

    assign accept   = start && !busy;
    assign in_range = (32'(row_index) < imm_pkg::MAX_DIM) && (32'(col_index) < imm_pkg::MAX_DIM);
    assign we_a     = accept && in_range && (kind == imm_pkg::KIND_LOAD_A);
    assign we_b     = accept && in_range && (kind == imm_pkg::KIND_LOAD_B);
    assign go       = accept && (kind == imm_pkg::KIND_START);
    assign waddr    = imm_pkg::ADDR_W'(imm_pkg::ADDR_W'(row_index)
                      * imm_pkg::ADDR_W'(imm_pkg::MAX_DIM)) + imm_pkg::ADDR_W'(col_index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= imm_pkg::CFG_W'(8);
            inner_reg <= imm_pkg::CFG_W'(8);
            cols_reg  <= imm_pkg::CFG_W'(8);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                imm_pkg::CFG_ROWS:  rows_reg  <= cfg_data;
                imm_pkg::CFG_INNER: inner_reg <= cfg_data;
                imm_pkg::CFG_COLS:  cols_reg  <= cfg_data;
                default:            rows_reg  <= rows_reg;
            endcase
        end
    end

    imm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .cfg_rows  (rows_reg),
        .cfg_inner (inner_reg),
        .cfg_cols  (cols_reg),
        .busy      (busy),
        .a_raddr   (a_raddr),
        .b_raddr   (b_raddr),
        .tag       (tag)
    );

    imm_ram #(
        .WIDTH  (imm_pkg::DATA_W),
        .DEPTH  (imm_pkg::DEPTH),
        .ADDR_W (imm_pkg::ADDR_W)
    ) u_a_store (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (we_a),
        .waddr (waddr),
        .wdata (value),
        .raddr (a_raddr),
        .rdata (a_data)
    );

    imm_ram #(
        .WIDTH  (imm_pkg::DATA_W),
        .DEPTH  (imm_pkg::DEPTH),
        .ADDR_W (imm_pkg::ADDR_W)
    ) u_b_store (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (we_b),
        .waddr (waddr),
        .wdata (value),
        .raddr (b_raddr),
        .rdata (b_data)
    );

    imm_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .tag    (tag),
        .a_data (a_data),
        .b_data (b_data),
        .strobe (result_strobe),
        .row    (out_row),
        .col    (out_col),
        .sum    (sum),
        .last   (last)
    );

    assign product_value = sum;

`ifndef SYNTHESIS
    // a result beat only follows a busy cycle
    a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(busy))
        else $error("result beat without a running multiply");

    a_last_with_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> result_strobe)
        else $error("last raised outside a result beat");

    // the final beat of a run is shown with the block already free
    a_last_frees_block: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && last) |-> !busy)
        else $error("busy still high on the final result beat");

    a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        go |=> busy)
        else $error("start of a multiply did not raise busy");

    a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !(we_a || we_b))
        else $error("store written during a multiply");
`endif

endmodule
`default_nettype wire

### design/imm_ram.sv
// single write, single read store with registered read and per-entry valid bits
`timescale 1ns / 1ps
`default_nettype none
module imm_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rdata_reg;
    logic             hit_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            hit_reg <= valid_reg[raddr];
        end
    end

    // entries never written read as zero
    assign rdata = hit_reg ? rdata_reg : '0;

endmodule
`default_nettype wire

### design/imm_mac.sv
// multiply-accumulate unit: product register, accumulator and result register
`timescale 1ns / 1ps
`default_nettype none
module imm_mac (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire imm_pkg::issue_tag_t          tag,
    input  wire logic [imm_pkg::DATA_W-1:0]   a_data,
    input  wire logic [imm_pkg::DATA_W-1:0]   b_data,
    output logic                              strobe,
    output logic [imm_pkg::IDX_W-1:0]         row,
    output logic [imm_pkg::IDX_W-1:0]         col,
    output logic [imm_pkg::DATA_W-1:0]        sum,
    output logic                              last
);

    imm_pkg::issue_tag_t              tag1_reg;
    imm_pkg::issue_tag_t              tag2_reg;
    logic [imm_pkg::DATA_W-1:0]       prod_reg;
    logic [imm_pkg::DATA_W-1:0]       acc_reg;
    logic [imm_pkg::DATA_W-1:0]       acc_next;
    logic                             strobe_reg;
    logic [imm_pkg::IDX_W-1:0]        row_reg;
    logic [imm_pkg::IDX_W-1:0]        col_reg;
    logic [imm_pkg::DATA_W-1:0]       sum_reg;
    logic                             last_reg;

    // low word of the product, wraps like the accumulator
    always_ff @(posedge clk)
    begin
        prod_reg <= imm_pkg::DATA_W'(a_data * b_data);
    end

    assign acc_next = (tag2_reg.first ? '0 : acc_reg) + prod_reg;

    always_ff @(posedge clk)
    begin
        if (tag2_reg.valid)
        begin
            acc_reg <= acc_next;
        end
        if (tag2_reg.valid && tag2_reg.last_k)
        begin
            row_reg  <= imm_pkg::IDX_W'(tag2_reg.row);
            col_reg  <= imm_pkg::IDX_W'(tag2_reg.col);
            sum_reg  <= acc_next;
            last_reg <= tag2_reg.last_el;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg   <= '0;
            tag2_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            tag1_reg   <= tag;
            tag2_reg   <= tag1_reg;
            strobe_reg <= tag2_reg.valid && tag2_reg.last_k;
        end
    end

    assign strobe = strobe_reg;
    assign row    = row_reg;
    assign col    = col_reg;
    assign sum    = sum_reg;
    assign last   = strobe_reg && last_reg;

endmodule
`default_nettype wire

### design/imm_ctrl.sv
// sequencer: walks row, column and inner index and issues store reads
`timescale 1ns / 1ps
`default_nettype none
module imm_ctrl (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         go,
    input  wire logic [imm_pkg::CFG_W-1:0]    cfg_rows,
    input  wire logic [imm_pkg::CFG_W-1:0]    cfg_inner,
    input  wire logic [imm_pkg::CFG_W-1:0]    cfg_cols,
    output logic                              busy,
    output logic [imm_pkg::ADDR_W-1:0]        a_raddr,
    output logic [imm_pkg::ADDR_W-1:0]        b_raddr,
    output imm_pkg::issue_tag_t               tag
);

    imm_pkg::state_t              state_reg, state_next;
    logic [imm_pkg::CNT_W-1:0]    i_reg, i_next;
    logic [imm_pkg::CNT_W-1:0]    j_reg, j_next;
    logic [imm_pkg::CNT_W-1:0]    k_reg, k_next;
    logic [imm_pkg::CNT_W-1:0]    nr_reg, nr_next;
    logic [imm_pkg::CNT_W-1:0]    nk_reg, nk_next;
    logic [imm_pkg::CNT_W-1:0]    nc_reg, nc_next;
    logic [1:0]                   drain_reg, drain_next;
    logic                         last_k;
    logic                         last_el;

    assign last_k  = (k_reg == nk_reg);
    assign last_el = last_k && (i_reg == nr_reg) && (j_reg == nc_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            imm_pkg::ST_IDLE:
            begin
                if (go)
                begin
                    state_next = imm_pkg::ST_ISSUE;
                end
            end
            imm_pkg::ST_ISSUE:
            begin
                if (last_el)
                begin
                    state_next = imm_pkg::ST_DRAIN;
                end
            end
            imm_pkg::ST_DRAIN:
            begin
                if (drain_reg == imm_pkg::DRAIN_LAST)
                begin
                    state_next = imm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = imm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        nr_next    = nr_reg;
        nk_next    = nk_reg;
        nc_next    = nc_reg;
        drain_next = '0;
        case (state_reg)
            imm_pkg::ST_IDLE:
            begin
                if (go)
                begin
                    i_next  = '0;
                    j_next  = '0;
                    k_next  = '0;
                    nr_next = imm_pkg::dim_last(cfg_rows);
                    nk_next = imm_pkg::dim_last(cfg_inner);
                    nc_next = imm_pkg::dim_last(cfg_cols);
                end
            end
            imm_pkg::ST_ISSUE:
            begin
                if (!last_k)
                begin
                    k_next = k_reg + 1'b1;
                end
                else
                begin
                    k_next = '0;
                    if (j_reg != nc_reg)
                    begin
                        j_next = j_reg + 1'b1;
                    end
                    else
                    begin
                        j_next = '0;
                        i_next = i_reg + 1'b1;
                    end
                end
            end
            imm_pkg::ST_DRAIN:
            begin
                drain_next = drain_reg + 2'd1;
            end
            default:
            begin
                drain_next = '0;
            end
        endcase
    end

    always_comb
    begin
        busy        = (state_reg != imm_pkg::ST_IDLE);
        tag.valid   = (state_reg == imm_pkg::ST_ISSUE);
        tag.first   = (k_reg == '0);
        tag.last_k  = last_k;
        tag.last_el = last_el;
        tag.row     = i_reg;
        tag.col     = j_reg;
        // row-major with stride MAX_DIM
        a_raddr = imm_pkg::ADDR_W'(imm_pkg::ADDR_W'(i_reg) * imm_pkg::ADDR_W'(imm_pkg::MAX_DIM))
                  + imm_pkg::ADDR_W'(k_reg);
        b_raddr = imm_pkg::ADDR_W'(imm_pkg::ADDR_W'(k_reg) * imm_pkg::ADDR_W'(imm_pkg::MAX_DIM))
                  + imm_pkg::ADDR_W'(j_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= imm_pkg::ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            nr_reg    <= '0;
            nk_reg    <= '0;
            nc_reg    <= '0;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            nr_reg    <= nr_next;
            nk_reg    <= nk_next;
            nc_reg    <= nc_next;
            drain_reg <= drain_next;
        end
    end

endmodule
`default_nettype wire
